// ----- design/ckb_pkg.sv -----
`timescale 1ns / 1ps

package ckb_pkg;

  localparam int WordWidth = 32;
  localparam int NumWords  = 16;
  localparam int PairWidth = 64;
  localparam int CfgWidth  = 64;
  localparam int IdxWidth  = 3;
  localparam int PosWidth  = 3;
  localparam int DrWidth   = 4;

  // Configuration register indexes.
  localparam logic [IdxWidth-1:0] REG_KEY_PART_0    = 3'd0;
  localparam logic [IdxWidth-1:0] REG_KEY_PART_1    = 3'd1;
  localparam logic [IdxWidth-1:0] REG_KEY_PART_2    = 3'd2;
  localparam logic [IdxWidth-1:0] REG_KEY_PART_3    = 3'd3;
  localparam logic [IdxWidth-1:0] REG_NONCE_LOW     = 3'd4;
  localparam logic [IdxWidth-1:0] REG_NONCE_HIGH    = 3'd5;
  localparam logic [IdxWidth-1:0] REG_DOUBLE_ROUNDS = 3'd6;

  localparam logic [DrWidth-1:0] DoubleRoundsReset = 4'd10;
  localparam logic [PosWidth-1:0] LastPos = 3'd7;

  // "expand 32-byte k"
  localparam logic [WordWidth-1:0] Sigma0 = 32'h6170_7865;
  localparam logic [WordWidth-1:0] Sigma1 = 32'h3320_646e;
  localparam logic [WordWidth-1:0] Sigma2 = 32'h7962_2d32;
  localparam logic [WordWidth-1:0] Sigma3 = 32'h6b20_6574;

  typedef logic [NumWords-1:0][WordWidth-1:0] words_t;

  typedef struct packed {
    logic [CfgWidth-1:0]  key_part_0;
    logic [CfgWidth-1:0]  key_part_1;
    logic [CfgWidth-1:0]  key_part_2;
    logic [CfgWidth-1:0]  key_part_3;
    logic [CfgWidth-1:0]  nonce_low;
    logic [WordWidth-1:0] nonce_high;
    logic [DrWidth-1:0]   double_rounds;
  } cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                load;    // build the initial state from a new counter
    logic                round;   // apply one column or diagonal round
    logic                diag;    // the round is a diagonal round
    logic                finish;  // add the initial state back in
    logic [PosWidth-1:0] pos;     // pair presented on the output
  } cmd_t;

  typedef struct packed {
    logic [WordWidth-1:0] a;
    logic [WordWidth-1:0] b;
    logic [WordWidth-1:0] c;
    logic [WordWidth-1:0] d;
  } qr_t;

  function automatic logic [WordWidth-1:0] rotl(input logic [WordWidth-1:0] v,
                                                input int n);
    return (v << n) | (v >> (WordWidth - n));
  endfunction

  function automatic qr_t quarter(input qr_t x);
    qr_t r;
    r = x;
    r.a = r.a + r.b; r.d = rotl(r.d ^ r.a, 16);
    r.c = r.c + r.d; r.b = rotl(r.b ^ r.c, 12);
    r.a = r.a + r.b; r.d = rotl(r.d ^ r.a, 8);
    r.c = r.c + r.d; r.b = rotl(r.b ^ r.c, 7);
    return r;
  endfunction

  function automatic words_t init_state(input cfg_t cfg,
                                        input logic [WordWidth-1:0] counter);
    words_t s;
    s[0]  = Sigma0;
    s[1]  = Sigma1;
    s[2]  = Sigma2;
    s[3]  = Sigma3;
    s[4]  = cfg.key_part_0[31:0];
    s[5]  = cfg.key_part_0[63:32];
    s[6]  = cfg.key_part_1[31:0];
    s[7]  = cfg.key_part_1[63:32];
    s[8]  = cfg.key_part_2[31:0];
    s[9]  = cfg.key_part_2[63:32];
    s[10] = cfg.key_part_3[31:0];
    s[11] = cfg.key_part_3[63:32];
    s[12] = counter;
    s[13] = cfg.nonce_low[31:0];
    s[14] = cfg.nonce_low[63:32];
    s[15] = cfg.nonce_high;
    return s;
  endfunction

endpackage

// ----- design/ckb_if.sv -----
`timescale 1ns / 1ps

interface ckb_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] block_counter;

  modport source (output valid, output block_counter, input ready);
  modport sink (input valid, input block_counter, output ready);
endinterface

interface ckb_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] keystream_pair;
  logic [2:0]  pair_index;
  logic        last_pair;

  modport source (output valid, output keystream_pair, output pair_index,
                  output last_pair, input ready);
  modport sink (input valid, input keystream_pair, input pair_index,
                input last_pair, output ready);
endinterface

// ----- design/ckb_datapath.sv -----
`timescale 1ns / 1ps

module ckb_datapath
  import ckb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  cmd_t                 cmd,
  input  logic [WordWidth-1:0] block_counter,
  output logic [PairWidth-1:0] keystream_pair,
  output logic [PosWidth-1:0]  pair_index,
  output logic                 last_pair
);

  words_t               words;
  words_t               round_next;
  words_t               finish_next;
  words_t               init_held;
  logic [WordWidth-1:0] held_counter;

  assign init_held = init_state(cfg, held_counter);

  // Four quarter rounds side by side: columns, or diagonals when cmd.diag.
  always_comb begin
    qr_t q;
    round_next = words;
    for (int i = 0; i < 4; i++) begin
      if (cmd.diag) begin
        q.a = words[4'(i)];
        q.b = words[4'(4 + ((i + 1) & 3))];
        q.c = words[4'(8 + ((i + 2) & 3))];
        q.d = words[4'(12 + ((i + 3) & 3))];
        q = quarter(q);
        round_next[4'(i)]                  = q.a;
        round_next[4'(4 + ((i + 1) & 3))]  = q.b;
        round_next[4'(8 + ((i + 2) & 3))]  = q.c;
        round_next[4'(12 + ((i + 3) & 3))] = q.d;
      end else begin
        q.a = words[4'(i)];
        q.b = words[4'(4 + i)];
        q.c = words[4'(8 + i)];
        q.d = words[4'(12 + i)];
        q = quarter(q);
        round_next[4'(i)]      = q.a;
        round_next[4'(4 + i)]  = q.b;
        round_next[4'(8 + i)]  = q.c;
        round_next[4'(12 + i)] = q.d;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NumWords; i++) begin
      finish_next[i] = words[i] + init_held[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_counter <= '0;
    end else if (cmd.load) begin
      held_counter <= block_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      words <= init_state(cfg, block_counter);
    end else if (cmd.round) begin
      words <= round_next;
    end else if (cmd.finish) begin
      words <= finish_next;
    end
  end

  assign keystream_pair = {words[{cmd.pos, 1'b1}], words[{cmd.pos, 1'b0}]};
  assign pair_index     = cmd.pos;
  assign last_pair      = (cmd.pos == LastPos);

endmodule

// ----- design/ckb_ctrl.sv -----
`timescale 1ns / 1ps

module ckb_ctrl
  import ckb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [DrWidth-1:0] double_rounds,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output cmd_t               cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ROUND = 2'd1;
  localparam logic [1:0] ST_FINAL = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [DrWidth-1:0]  round_cnt;
  logic [DrWidth-1:0]  round_cnt_next;
  logic                phase;
  logic                phase_next;
  logic [PosWidth-1:0] pos;
  logic [PosWidth-1:0] pos_next;
  logic                in_take;
  logic                out_take;

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_EMIT);
  assign in_take   = in_valid && in_ready;
  assign out_take  = out_valid && out_ready;

  always_comb begin
    state_next     = state;
    round_cnt_next = round_cnt;
    phase_next     = phase;
    pos_next       = pos;
    case (state)
      ST_IDLE: begin
        round_cnt_next = '0;
        phase_next     = 1'b0;
        pos_next       = '0;
        if (in_take) begin
          state_next = (double_rounds == '0) ? ST_FINAL : ST_ROUND;
        end
      end
      ST_ROUND: begin
        phase_next = ~phase;
        if (phase) begin
          round_cnt_next = round_cnt + 4'd1;
          if (round_cnt == double_rounds - 4'd1) begin
            state_next = ST_FINAL;
          end
        end
      end
      ST_FINAL: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_take) begin
          pos_next = pos + 3'd1;
          if (pos == LastPos) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      round_cnt <= '0;
      phase     <= 1'b0;
      pos       <= '0;
    end else begin
      state     <= state_next;
      round_cnt <= round_cnt_next;
      phase     <= phase_next;
      pos       <= pos_next;
    end
  end

  assign cmd.load   = in_take;
  assign cmd.round  = (state == ST_ROUND);
  assign cmd.diag   = phase;
  assign cmd.finish = (state == ST_FINAL);
  assign cmd.pos    = pos;

  // A block is never taken while a pair is on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while results pending");

  // The final pair sends the controller back to idle.
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_take && pos == LastPos) |=> (state == ST_IDLE))
    else $error("controller did not return to idle after the last pair");

  // A waiting pair keeps its position.
  a_pos_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(pos)))
    else $error("pair position moved while stalled");

  // Rounds always end on a diagonal half.
  a_final_after_diag: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND && state_next == ST_FINAL) |-> phase)
    else $error("rounds ended after a column round");

endmodule

// ----- design/chacha_keystream_block_unit.sv -----
// One block counter is worked on at a time; the next is taken only once its eight pairs
// have gone out. One shared round unit does a column or a diagonal round per cycle, and
// output stalls can stretch the 8 output beats that close each block.
// Reset (rst, synchronous, active high): the controller goes idle, the key and nonce clear
//   to zero and double_rounds returns to ten; the working words are not cleared.
`timescale 1ns / 1ps

module chacha_keystream_block_unit
  import ckb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [IdxWidth-1:0] cfg_index,
  input  logic [CfgWidth-1:0] cfg_data,
  ckb_in_if.sink              counter_ch,
  ckb_out_if.source           keystream_ch
);

  // Configuration registers. The host must write them only while no block is in flight;
  // the unit does not enforce it. The datapath rebuilds the initial state at the finish.
  cfg_t cfg;
  cmd_t cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_part_0    <= '0;
      cfg.key_part_1    <= '0;
      cfg.key_part_2    <= '0;
      cfg.key_part_3    <= '0;
      cfg.nonce_low     <= '0;
      cfg.nonce_high    <= '0;
      cfg.double_rounds <= DoubleRoundsReset;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_KEY_PART_0:    cfg.key_part_0    <= cfg_data;
        REG_KEY_PART_1:    cfg.key_part_1    <= cfg_data;
        REG_KEY_PART_2:    cfg.key_part_2    <= cfg_data;
        REG_KEY_PART_3:    cfg.key_part_3    <= cfg_data;
        REG_NONCE_LOW:     cfg.nonce_low     <= cfg_data;
        REG_NONCE_HIGH:    cfg.nonce_high    <= cfg_data[WordWidth-1:0];
        REG_DOUBLE_ROUNDS: cfg.double_rounds <= cfg_data[DrWidth-1:0];
        default: begin
          // Writes to an unused index are dropped.
        end
      endcase
    end
  end

  // The controller sequences one block at a time: load the initial state on the input
  // transaction, run a column then a diagonal round per double round, add the initial
  // state back in, and offer the eight pairs one per transaction, lowest pair first.
  ckb_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .double_rounds (cfg.double_rounds),
    .in_valid      (counter_ch.valid),
    .in_ready      (counter_ch.ready),
    .out_valid     (keystream_ch.valid),
    .out_ready     (keystream_ch.ready),
    .cmd           (cmd)
  );

  // The datapath holds the sixteen working words and the round unit. The output pair is
  // selected from the held words, which do not move while a pair waits to be taken.
  ckb_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cmd            (cmd),
    .block_counter  (counter_ch.block_counter),
    .keystream_pair (keystream_ch.keystream_pair),
    .pair_index     (keystream_ch.pair_index),
    .last_pair      (keystream_ch.last_pair)
  );

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

// Testbench for the ChaCha keystream block unit.
//
// Block counters are queued by the stimulus process and handed to the unit by a clocked
// driver. Every counter transaction that the unit accepts is run through the behavioural
// ChaCha block function below, using the testbench's own copy of the key, the nonce and the
// round count. The eight 64-bit pairs it produces are queued in order, and a clocked monitor
// compares each keystream transaction against the oldest pair that is still waiting.
//
// The configuration only changes while the unit is idle, so the copy that is used to
// predict a block is always the one that the hardware is using at the same moment.
module testbench;
  import ckb_pkg::*;

  // Index 7 lies beyond the register list, so a write to it must change nothing.
  localparam logic [IdxWidth-1:0] NoSuchReg = 3'd7;

  // The slowest block runs fifteen double rounds before its first pair, and output
  // stalls stretch the eight beats that follow. QuietLimit is far beyond any gap that
  // a working unit could produce.
  localparam int QuietLimit    = 2000;
  localparam int TailCycles    = 64;
  localparam int RandomPhases  = 8;
  localparam int ItemsPerPhase = 52;

  typedef struct packed {
    logic [PairWidth-1:0] pair;
    logic [PosWidth-1:0]  index;
    logic                 is_last;
  } keystream_beat_t;

  logic                clk;
  logic                rst;
  logic                cfg_write;
  logic [IdxWidth-1:0] cfg_index;
  logic [CfgWidth-1:0] cfg_data;

  ckb_in_if  counter_ch ();
  ckb_out_if keystream_ch ();

  chacha_keystream_block_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .counter_ch   (counter_ch),
    .keystream_ch (keystream_ch)
  );

  // The testbench's view of the configuration registers, kept in step with every write.
  logic [CfgWidth-1:0]  key_cfg [4];
  logic [CfgWidth-1:0]  nonce_lo_cfg;
  logic [WordWidth-1:0] nonce_hi_cfg;
  logic [DrWidth-1:0]   rounds_cfg;

  logic [WordWidth-1:0] pending_counters [$];
  keystream_beat_t      expected_pairs [$];
  int                   mismatch_count;
  int                   quiet_cycles;

  // While calm is set, neither side inserts idle cycles.
  logic                 calm;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [WordWidth-1:0] rol32(input logic [WordWidth-1:0] v,
                                                 input int unsigned n);
    return (v << n) | (v >> (WordWidth - n));
  endfunction

  // A quarter round applied in place to four words of the sixteen-word state.
  function automatic words_t mix_quarter(input words_t w, input int a, input int b,
                                         input int c, input int d);
    words_t m;
    m = w;
    m[a] = m[a] + m[b]; m[d] = rol32(m[d] ^ m[a], 16);
    m[c] = m[c] + m[d]; m[b] = rol32(m[b] ^ m[c], 12);
    m[a] = m[a] + m[b]; m[d] = rol32(m[d] ^ m[a], 8);
    m[c] = m[c] + m[d]; m[b] = rol32(m[b] ^ m[c], 7);
    return m;
  endfunction

  // Works out the full keystream block for one counter and queues its eight pairs.
  function automatic void predict_keystream(input logic [WordWidth-1:0] counter);
    words_t               start_words;
    words_t               mixed;
    logic [WordWidth-1:0] lo_word;
    logic [WordWidth-1:0] hi_word;
    keystream_beat_t      beat;
    start_words[0] = Sigma0;
    start_words[1] = Sigma1;
    start_words[2] = Sigma2;
    start_words[3] = Sigma3;
    for (int i = 0; i < 4; i++) begin
      start_words[4 + 2 * i] = key_cfg[i][31:0];
      start_words[5 + 2 * i] = key_cfg[i][63:32];
    end
    start_words[12] = counter;
    start_words[13] = nonce_lo_cfg[31:0];
    start_words[14] = nonce_lo_cfg[63:32];
    start_words[15] = nonce_hi_cfg;
    mixed = start_words;
    // A round count of zero leaves the state untouched, so each word simply doubles.
    for (int r = 0; r < int'(rounds_cfg); r++) begin
      mixed = mix_quarter(mixed, 0, 4, 8, 12);
      mixed = mix_quarter(mixed, 1, 5, 9, 13);
      mixed = mix_quarter(mixed, 2, 6, 10, 14);
      mixed = mix_quarter(mixed, 3, 7, 11, 15);
      mixed = mix_quarter(mixed, 0, 5, 10, 15);
      mixed = mix_quarter(mixed, 1, 6, 11, 12);
      mixed = mix_quarter(mixed, 2, 7, 8, 13);
      mixed = mix_quarter(mixed, 3, 4, 9, 14);
    end
    for (int k = 0; k < 8; k++) begin
      lo_word        = mixed[2 * k] + start_words[2 * k];
      hi_word        = mixed[2 * k + 1] + start_words[2 * k + 1];
      beat.pair      = {hi_word, lo_word};
      beat.index     = PosWidth'(k);
      beat.is_last   = (PosWidth'(k) == LastPos);
      expected_pairs = {expected_pairs, beat};
    end
  endfunction

  // Counter driver. A transaction that is being offered stays on the bus until the unit
  // takes it; only then may the next one from the queue be offered, or an idle cycle
  // inserted. The prediction is made at the very edge at which the unit accepts it.
  always @(posedge clk) begin : counter_driver
    logic hold_off;
    hold_off = !calm && ($urandom_range(99) < 25);
    if (rst) begin
      counter_ch.valid <= 1'b0;
    end else begin
      if (counter_ch.valid && counter_ch.ready) begin
        predict_keystream(counter_ch.block_counter);
      end
      if (!counter_ch.valid || counter_ch.ready) begin
        if (pending_counters.size() != 0 && !hold_off) begin
          counter_ch.valid         <= 1'b1;
          counter_ch.block_counter <= pending_counters.pop_front();
        end else begin
          counter_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Keystream monitor. Each accepted transaction is checked field by field against the
  // oldest predicted pair; ready is withdrawn at random to exercise output back-pressure.
  always @(posedge clk) begin : keystream_monitor
    keystream_beat_t want;
    if (rst) begin
      keystream_ch.ready <= 1'b0;
    end else begin
      if (keystream_ch.valid && keystream_ch.ready) begin
        if (expected_pairs.size() == 0) begin
          $error("keystream_pair: expected nothing, got %h", keystream_ch.keystream_pair);
          mismatch_count++;
        end else begin
          want = expected_pairs.pop_front();
          if (keystream_ch.keystream_pair !== want.pair) begin
            $error("keystream_pair: expected %h, got %h", want.pair,
                   keystream_ch.keystream_pair);
            mismatch_count++;
          end
          if (keystream_ch.pair_index !== want.index) begin
            $error("pair_index: expected %0d, got %0d", want.index,
                   keystream_ch.pair_index);
            mismatch_count++;
          end
          if (keystream_ch.last_pair !== want.is_last) begin
            $error("last_pair: expected %0b, got %0b", want.is_last,
                   keystream_ch.last_pair);
            mismatch_count++;
          end
        end
      end
      keystream_ch.ready <= calm || ($urandom_range(99) >= 25);
    end
  end

  // Watchdog: the run is abandoned if nothing at all moves for too long.
  always @(posedge clk) begin : watchdog
    if (rst || cfg_write || (counter_ch.valid && counter_ch.ready) ||
        (keystream_ch.valid && keystream_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Adds one counter to the end of the driver's queue.
  task automatic queue_counter(input logic [WordWidth-1:0] c);
    pending_counters = {pending_counters, c};
  endtask

  // Writes one register and mirrors the effect in the testbench's copy. Values wider than
  // the register are cut to its width, and writes to an unknown index are dropped.
  task automatic write_reg(input logic [IdxWidth-1:0] idx, input logic [CfgWidth-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_KEY_PART_0:    key_cfg[0]   = val;
      REG_KEY_PART_1:    key_cfg[1]   = val;
      REG_KEY_PART_2:    key_cfg[2]   = val;
      REG_KEY_PART_3:    key_cfg[3]   = val;
      REG_NONCE_LOW:     nonce_lo_cfg = val;
      REG_NONCE_HIGH:    nonce_hi_cfg = val[WordWidth-1:0];
      REG_DOUBLE_ROUNDS: rounds_cfg   = val[DrWidth-1:0];
      default: ;
    endcase
  endtask

  // Holds the stimulus back until every queued counter has been taken and every predicted
  // pair has come out, then lets the unit settle. The check is made at the falling edge,
  // once everything that the rising edge changed has settled.
  task automatic wait_drained();
    while (pending_counters.size() != 0 || counter_ch.valid || expected_pairs.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [CfgWidth-1:0]  raw;
    logic [WordWidth-1:0] counter;
    logic [DrWidth-1:0]   rounds;

    rst                      = 1'b1;
    cfg_write                = 1'b0;
    cfg_index                = '0;
    cfg_data                 = '0;
    counter_ch.valid         = 1'b0;
    counter_ch.block_counter = '0;
    keystream_ch.ready       = 1'b0;
    calm                     = 1'b0;
    mismatch_count           = 0;
    quiet_cycles             = 0;
    for (int i = 0; i < 4; i++) key_cfg[i] = '0;
    nonce_lo_cfg = '0;
    nonce_hi_cfg = '0;
    rounds_cfg   = DoubleRoundsReset;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Straight out of reset: zero key and nonce, ten double rounds. The counter extremes
    // and the top bit on its own are tried here.
    queue_counter(32'h0000_0000);
    queue_counter(32'hffff_ffff);
    queue_counter(32'h8000_0000);
    queue_counter(32'h7fff_ffff);
    wait_drained();

    // The well-known ChaCha20 block with a byte-sequence key, which gives a sanity check
    // of word and byte ordering on top of the prediction.
    write_reg(REG_KEY_PART_0, 64'h0706_0504_0302_0100);
    write_reg(REG_KEY_PART_1, 64'h0f0e_0d0c_0b0a_0908);
    write_reg(REG_KEY_PART_2, 64'h1716_1514_1312_1110);
    write_reg(REG_KEY_PART_3, 64'h1f1e_1d1c_1b1a_1918);
    write_reg(REG_NONCE_LOW, 64'h4a00_0000_0900_0000);
    write_reg(REG_NONCE_HIGH, 64'h0);
    queue_counter(32'h0000_0001);
    wait_drained();

    // Everything at all ones. The nonce word and the round count are written with bits
    // beyond their width, which the unit must discard; fifteen rounds is the maximum.
    for (int i = 0; i < 4; i++) write_reg(IdxWidth'(REG_KEY_PART_0 + i), '1);
    write_reg(REG_NONCE_LOW, '1);
    write_reg(REG_NONCE_HIGH, '1);
    write_reg(REG_DOUBLE_ROUNDS, '1);
    queue_counter(32'h0000_0000);
    queue_counter(32'hffff_ffff);
    wait_drained();

    // No rounds at all: the output is simply the initial state doubled.
    write_reg(REG_DOUBLE_ROUNDS, 64'hdead_beef_cafe_00f0);
    queue_counter(32'h1234_5678);
    queue_counter(32'hffff_ffff);
    wait_drained();

    // A single double round; the upper half of the nonce data must again be dropped.
    write_reg(REG_DOUBLE_ROUNDS, 64'h1);
    write_reg(REG_NONCE_HIGH, 64'h1234_5678_0000_0000);
    queue_counter(32'h0000_0000);
    queue_counter(32'h5555_aaaa);
    wait_drained();

    // A write beyond the register list must leave the configuration as it was.
    write_reg(NoSuchReg, '1);
    queue_counter(32'ha5a5_5a5a);
    wait_drained();

    // Random part. Each phase sets a fresh random configuration while the unit is idle,
    // forcing the round count to its extremes in the first few phases, then streams
    // random counters. One phase runs without any idle cycles on either side, and in
    // another the sender stops halfway until every pair has come back.
    for (int phase = 0; phase < RandomPhases; phase++) begin
      for (int i = 0; i < 4; i++) write_reg(IdxWidth'(REG_KEY_PART_0 + i), {$urandom, $urandom});
      write_reg(REG_NONCE_LOW, {$urandom, $urandom});
      write_reg(REG_NONCE_HIGH, {$urandom, $urandom});
      case (phase)
        0:       rounds = 4'd0;
        1:       rounds = 4'hf;
        2:       rounds = 4'd1;
        3:       rounds = DoubleRoundsReset;
        default: rounds = DrWidth'($urandom_range(15));
      endcase
      raw                = {$urandom, $urandom};
      raw[DrWidth-1:0]   = rounds;
      write_reg(REG_DOUBLE_ROUNDS, raw);
      if (phase % 3 == 1) write_reg(NoSuchReg, {$urandom, $urandom});
      calm = (phase == 4);
      for (int n = 0; n < ItemsPerPhase; n++) begin
        case ($urandom_range(7))
          0:       counter = '0;
          1:       counter = '1;
          2:       counter = WordWidth'($urandom_range(3));
          default: counter = $urandom;
        endcase
        queue_counter(counter);
        if (phase == 5 && n == ItemsPerPhase / 2) wait_drained();
      end
      wait_drained();
      calm = 1'b0;
    end

    repeat (TailCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- chacha_keystream_block_unit.f -----
design/ckb_pkg.sv
design/ckb_if.sv
design/ckb_datapath.sv
design/ckb_ctrl.sv
design/chacha_keystream_block_unit.sv
verif/testbench.sv
